FILE: rtl/cts_pkg.sv
// shared constants, types and table builders for the chord tone synthesizer
package cts_pkg;

   localparam int MAX_VOICES      = 6;
   localparam int PHASE_BITS      = 24;
   localparam int TABLE_ADDR_BITS = 10;
   localparam int SAMPLE_BITS     = 16;

   localparam int STEP_BITS      = 23;
   localparam int COUNT_BITS     = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 23;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOICE_COUNT = CSR_INDEX_BITS'(0);
   localparam int                        CSR_STEP_BASE   = 1;

   localparam int VOICE_BITS = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int VCNT_BITS  = $clog2(MAX_VOICES + 1);

   localparam int TBL_N         = 1 << TABLE_ADDR_BITS;
   localparam int ROM_ADDR_BITS = TABLE_ADDR_BITS + 1;
   localparam int MAG_BITS      = SAMPLE_BITS - 1;
   localparam int AMP           = (1 << (SAMPLE_BITS - 1)) - 1;
   localparam int SUM_BITS      = MAG_BITS + $clog2(MAX_VOICES + 1) + 1;
   localparam int ABS_BITS      = SUM_BITS - 1;

   // reciprocal of the voice count, exact for sums below 2^18
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_BITS  = RECIP_SHIFT + 1;
   localparam int PROD_BITS   = ABS_BITS + RECIP_BITS;

   // ceil(2^RECIP_SHIFT / n) for each voice count from one to six
   localparam logic [RECIP_BITS-1:0] RECIP_2 = RECIP_BITS'(((1 << RECIP_SHIFT) + 1) / 2);
   localparam logic [RECIP_BITS-1:0] RECIP_3 = RECIP_BITS'(((1 << RECIP_SHIFT) + 2) / 3);
   localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'(((1 << RECIP_SHIFT) + 3) / 4);
   localparam logic [RECIP_BITS-1:0] RECIP_5 = RECIP_BITS'(((1 << RECIP_SHIFT) + 4) / 5);
   localparam logic [RECIP_BITS-1:0] RECIP_6 = RECIP_BITS'(((1 << RECIP_SHIFT) + 5) / 6);
   localparam logic [RECIP_BITS-1:0] RECIP_1 = RECIP_BITS'(1 << RECIP_SHIFT);

   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // series step divisors (2k)(2k+1) as ceil(2^48 / d), exact for terms below 2^33
   localparam int     SERIES_SHIFT   = 48;
   localparam longint SERIES_RECIP_1 = ((64'sd1 <<< SERIES_SHIFT) + 64'sd5) / 64'sd6;
   localparam longint SERIES_RECIP_2 = ((64'sd1 <<< SERIES_SHIFT) + 64'sd19) / 64'sd20;
   localparam longint SERIES_RECIP_3 = ((64'sd1 <<< SERIES_SHIFT) + 64'sd41) / 64'sd42;
   localparam longint SERIES_RECIP_4 = ((64'sd1 <<< SERIES_SHIFT) + 64'sd71) / 64'sd72;
   localparam longint SERIES_RECIP_5 = ((64'sd1 <<< SERIES_SHIFT) + 64'sd109) / 64'sd110;
   localparam longint SERIES_RECIP_6 = ((64'sd1 <<< SERIES_SHIFT) + 64'sd155) / 64'sd156;

   typedef logic [MAG_BITS-1:0] sine_rom_type [0:TBL_N];

   // truncating division of a non-negative term by the k-th series step
   function automatic longint series_div(input longint t, input int k);
      logic [127:0] m;
      logic [127:0] p;
      case (k)
         1:       m = 128'(SERIES_RECIP_1);
         2:       m = 128'(SERIES_RECIP_2);
         3:       m = 128'(SERIES_RECIP_3);
         4:       m = 128'(SERIES_RECIP_4);
         5:       m = 128'(SERIES_RECIP_5);
         default: m = 128'(SERIES_RECIP_6);
      endcase
      p = 128'(t) * m;
      return longint'(p >> SERIES_SHIFT);
   endfunction

   // quarter-wave table, q30 taylor series then scaled to full amplitude
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint x;
      longint x2;
      longint term;
      longint acc;
      for (int i = 0; i <= TBL_N; i++) begin
         x    = (HALF_PI_Q30 * longint'(i)) >>> TABLE_ADDR_BITS;
         x2   = (x * x) >>> 30;
         term = x;
         acc  = x;
         for (int k = 1; k <= 6; k++) begin
            term = series_div((term * x2) >>> 30, k);
            if (k[0]) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         rom[i] = MAG_BITS'((acc * longint'(AMP) + (64'sd1 <<< 29)) >>> 30);
      end
      return rom;
   endfunction

   // ceil(2^RECIP_SHIFT / n) for the clamped voice count
   function automatic logic [RECIP_BITS-1:0] recip(input logic [VCNT_BITS-1:0] n);
      logic [RECIP_BITS-1:0] r;
      case (n)
         VCNT_BITS'(2): r = RECIP_2;
         VCNT_BITS'(3): r = RECIP_3;
         VCNT_BITS'(4): r = RECIP_4;
         VCNT_BITS'(5): r = RECIP_5;
         VCNT_BITS'(6): r = RECIP_6;
         default:       r = RECIP_1;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/cts_sine_rom.sv
// quarter-wave sine rom with registered read
module cts_sine_rom (
   input  logic                                 clock,
   input  logic [cts_pkg::ROM_ADDR_BITS-1:0]    rd_addr,
   output logic [cts_pkg::MAG_BITS-1:0]         rd_data
);
   import cts_pkg::*;

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   logic [MAG_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= SINE_ROM[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/chord_tone_synthesizer_unit.sv
// chord tone synthesizer top level: voice sequencer, accumulator and averaging
// sequencing: one request at a time; the next is accepted only once the block is back in idle,
//   since the single phase adder and the one rom read port visit the voices one after another
// reset: synchronous, active high; voice count 1, all steps zero, all phases zero,
//   no response pending
module chord_tone_synthesizer_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cts_pkg::SAMPLE_BITS-1:0] rsp_sample,
   // register write port
   input  logic                                csr_write_en,
   input  logic [cts_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cts_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import cts_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a request
   localparam logic [2:0] ST_LOOK = 3'd1;  // rom address out, phase advance
   localparam logic [2:0] ST_ACC  = 3'd2;  // add signed table value
   localparam logic [2:0] ST_ADV  = 3'd3;  // advance the unsummed voices
   localparam logic [2:0] ST_MUL  = 3'd4;  // magnitude times reciprocal
   localparam logic [2:0] ST_DONE = 3'd5;  // load response register

   logic [2:0] state_ff, state_in;

   // configuration
   logic [COUNT_BITS-1:0] voice_count_ff;
   logic [STEP_BITS-1:0]  step_ff [MAX_VOICES];

   // voice state and datapath
   logic [PHASE_BITS-1:0]   phase_ff [MAX_VOICES];
   logic [VCNT_BITS-1:0]    voice_ff, voice_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic                    neg_ff, neg_in;
   logic                    sign_ff, sign_in;
   logic [PROD_BITS-1:0]    prod_ff, prod_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [VCNT_BITS-1:0]    n_eff;
   logic [VOICE_BITS-1:0]   vidx;
   logic [PHASE_BITS-1:0]   cur_phase;
   logic [PHASE_BITS-1:0]   next_phase;
   logic [1:0]              quad;
   logic [TABLE_ADDR_BITS-1:0] tidx;
   logic [ROM_ADDR_BITS-1:0] rom_addr;
   logic [MAG_BITS-1:0]     rom_data;
   logic [ABS_BITS-1:0]     sum_abs;
   logic [SAMPLE_BITS-1:0]  quot;
   logic [SAMPLE_BITS-1:0]  quot_sat;
   logic                    rsp_free;
   logic                    phase_we;

   // zero voices counts as one, more than the voice bank counts as all of it
   always_comb begin
      if (voice_count_ff == '0) begin
         n_eff = VCNT_BITS'(1);
      end else if ({1'b0, voice_count_ff} > (COUNT_BITS + 1)'(MAX_VOICES)) begin
         n_eff = VCNT_BITS'(MAX_VOICES);
      end else begin
         n_eff = VCNT_BITS'(voice_count_ff);
      end
   end

   // the one shared phase adder and the table address fold
   assign vidx       = voice_ff[VOICE_BITS-1:0];
   assign cur_phase  = phase_ff[vidx];
   assign next_phase = cur_phase + PHASE_BITS'(step_ff[vidx]);
   assign quad       = cur_phase[PHASE_BITS-1 -: 2];
   assign tidx       = cur_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];

   // odd quadrants mirror the quarter wave
   always_comb begin
      if (quad[0]) begin
         rom_addr = ROM_ADDR_BITS'(TBL_N) - {1'b0, tidx};
      end else begin
         rom_addr = {1'b0, tidx};
      end
   end

   cts_sine_rom u_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   // averaging: |sum| * ceil(2^24/n) >> 24 is exact truncation for our range
   assign sum_abs  = sum_ff[SUM_BITS-1] ? ABS_BITS'(-sum_ff) : ABS_BITS'(sum_ff);
   assign quot     = prod_ff[RECIP_SHIFT +: SAMPLE_BITS];
   assign quot_sat = (quot > SAMPLE_BITS'(AMP)) ? SAMPLE_BITS'(AMP) : quot;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      voice_in  = voice_ff;
      sum_in    = sum_ff;
      neg_in    = neg_ff;
      sign_in   = sign_ff;
      prod_in   = prod_ff;
      sample_in = sample_ff;
      phase_we  = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               voice_in = '0;
               sum_in   = '0;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            neg_in   = quad[1];
            phase_we = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (neg_ff) begin
               sum_in = sum_ff - $signed({{(SUM_BITS - MAG_BITS){1'b0}}, rom_data});
            end else begin
               sum_in = sum_ff + $signed({{(SUM_BITS - MAG_BITS){1'b0}}, rom_data});
            end
            voice_in = voice_ff + VCNT_BITS'(1);
            if (voice_ff == n_eff - VCNT_BITS'(1)) begin
               state_in = ST_ADV;
            end else begin
               state_in = ST_LOOK;
            end
         end
         ST_ADV: begin
            // voices past the count still advance every sample
            if (voice_ff == VCNT_BITS'(MAX_VOICES)) begin
               state_in = ST_MUL;
            end else begin
               phase_we = 1'b1;
               voice_in = voice_ff + VCNT_BITS'(1);
            end
         end
         ST_MUL: begin
            prod_in  = PROD_BITS'(sum_abs) * PROD_BITS'(recip(n_eff));
            sign_in  = sum_ff[SUM_BITS-1];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the response register is free
            if (rsp_free) begin
               sample_in    = sign_ff ? $signed(-quot_sat) : $signed(quot_sat);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         voice_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         voice_ff     <= voice_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      neg_ff    <= neg_in;
      sign_ff   <= sign_in;
      prod_ff   <= prod_in;
      sample_ff <= sample_in;
   end

   // phase bank: cleared on reset and on a restart request, else one voice per write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < MAX_VOICES; v++) begin
            phase_ff[v] <= '0;
         end
      end else if (state_ff == ST_IDLE && req_valid && req_restart) begin
         for (int v = 0; v < MAX_VOICES; v++) begin
            phase_ff[v] <= '0;
         end
      end else if (phase_we) begin
         phase_ff[vidx] <= next_phase;
      end
   end

   // register writes; unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         voice_count_ff <= COUNT_BITS'(1);
         for (int v = 0; v < MAX_VOICES; v++) begin
            step_ff[v] <= '0;
         end
      end else if (csr_write_en) begin
         if (csr_index == CSR_VOICE_COUNT) begin
            voice_count_ff <= csr_wdata[COUNT_BITS-1:0];
         end
         for (int v = 0; v < MAX_VOICES; v++) begin
            if (csr_index == CSR_INDEX_BITS'(CSR_STEP_BASE + v)) begin
               step_ff[v] <= csr_wdata[STEP_BITS-1:0];
            end
         end
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;

endmodule

FILE: tb/tb_chord_tone_synthesizer_unit.sv
// self-checking testbench for the chord tone synthesizer: directed table, then random chords
`timescale 1ns / 100ps

module tb_chord_tone_synthesizer_unit;
   import cts_pkg::*;

   // register index with no register behind it, writes must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE =
      CSR_INDEX_BITS'(CSR_STEP_BASE + MAX_VOICES);

   // a quarter turn per sample walks the four quadrant corners of the sine
   localparam logic [CSR_DATA_BITS-1:0] STEP_QUARTER = CSR_DATA_BITS'(1 << (PHASE_BITS - 2));
   localparam logic [CSR_DATA_BITS-1:0] STEP_FULL    = '1;

   localparam logic signed [SAMPLE_BITS-1:0] PEAK_POS = SAMPLE_BITS'(AMP);
   localparam logic signed [SAMPLE_BITS-1:0] PEAK_NEG = SAMPLE_BITS'(-AMP);

   // pi/2 in q30, the angle spanned by the quarter-wave table
   localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;

   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int PRESSURE_PHASE  = 3;
   localparam int LONG_HOLD       = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int REPORT_LIMIT    = 10;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   // one line of the directed plan: either a register write or one sample request
   typedef struct packed {
      row_kind_type                  kind;
      logic [CSR_INDEX_BITS-1:0]     index;
      logic [CSR_DATA_BITS-1:0]      data;
      logic                          restart;
      logic                          fixed;   // want holds the sample to expect
      logic signed [SAMPLE_BITS-1:0] want;
   } plan_row_type;

   localparam int DIRECTED_ROWS = 36;

   localparam plan_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      // out of reset: one voice, zero step, zero phase
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b1, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b1, '0},
      // one voice at a quarter turn per sample, count written with junk upper bits
      '{ROW_WRITE, CSR_INDEX_BITS'(CSR_STEP_BASE), STEP_QUARTER, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CSR_VOICE_COUNT, 23'h7ffff9, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b1, 1'b1, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b1, PEAK_POS},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b1, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b1, PEAK_NEG},
      // phase wraps back to zero
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b1, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b1, PEAK_POS},
      // restart in the middle of a chord
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b1, 1'b1, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b1, PEAK_POS},
      // voice count zero acts as one, largest step
      '{ROW_WRITE, CSR_VOICE_COUNT, '0, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CSR_INDEX_BITS'(CSR_STEP_BASE), STEP_FULL, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b1, 1'b1, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b0, '0},
      // count above the voice limit clamps to all voices
      '{ROW_WRITE, CSR_VOICE_COUNT, 23'd7, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CSR_INDEX_BITS'(CSR_STEP_BASE + 1), STEP_FULL, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CSR_INDEX_BITS'(CSR_STEP_BASE + 2), 23'd1, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CSR_INDEX_BITS'(CSR_STEP_BASE + 3), 23'h2aaaab, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CSR_INDEX_BITS'(CSR_STEP_BASE + 4), 23'h555555, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CSR_INDEX_BITS'(CSR_STEP_BASE + 5), 23'h123457, 1'b0, 1'b0, '0},
      // write to the unused index must not touch any step
      '{ROW_WRITE, CSR_SPARE, STEP_FULL, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b1, 1'b1, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b0, '0},
      // odd divisors, averages truncate toward zero
      '{ROW_WRITE, CSR_VOICE_COUNT, 23'd3, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CSR_VOICE_COUNT, 23'd5, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_VOICE_COUNT, '0, 1'b0, 1'b0, '0}
   };

   logic                                clock;
   logic                                reset        = 1'b1;
   logic                                req_valid    = 1'b0;
   logic                                req_ready;
   logic                                req_restart  = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready    = 1'b0;
   logic signed [SAMPLE_BITS-1:0]       rsp_sample;
   logic                                csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0]           csr_index    = '0;
   logic [CSR_DATA_BITS-1:0]            csr_wdata    = '0;

   chord_tone_synthesizer_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_sample   (rsp_sample),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // predictor state: mirrored registers and voice phases
   int                        quarter_wave [0:TBL_N];
   logic [COUNT_BITS-1:0]     voice_setting;
   logic [STEP_BITS-1:0]      tone_step  [MAX_VOICES];
   logic [PHASE_BITS-1:0]     tone_phase [MAX_VOICES];

   logic signed [SAMPLE_BITS-1:0] sample_expect_q [$];

   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   int  stall_left     = 0;
   bit  steady_flow    = 1'b0;   // no idling on either side
   bit  hold_request   = 1'b0;   // ask the receiver for one long hold-off

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly short pauses, now and then a long one
   function automatic int idle_span();
      if ($urandom_range(0, 9) < 7) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // expected sample for one tick, then advance every voice
   function automatic logic signed [SAMPLE_BITS-1:0] next_chord_sample(input logic restart);
      int                          voices;
      int                          total;
      int                          mean;
      int                          mag;
      logic [1:0]                  quad;
      logic [TABLE_ADDR_BITS-1:0]  slot;
      if (restart) begin
         foreach (tone_phase[v]) begin
            tone_phase[v] = '0;
         end
      end
      voices = int'(voice_setting);
      if (voices == 0) begin
         voices = 1;
      end
      if (voices > MAX_VOICES) begin
         voices = MAX_VOICES;
      end
      total = 0;
      for (int v = 0; v < voices; v++) begin
         quad = tone_phase[v][PHASE_BITS-1 -: 2];
         slot = tone_phase[v][PHASE_BITS-3 -: TABLE_ADDR_BITS];
         // odd quadrants read the table backwards, upper half is negated
         mag  = quad[0] ? quarter_wave[TBL_N - int'(slot)] : quarter_wave[slot];
         total += quad[1] ? -mag : mag;
      end
      mean = total / voices;
      if (mean > AMP) begin
         mean = AMP;
      end
      if (mean < -AMP) begin
         mean = -AMP;
      end
      // silent voices keep advancing too
      foreach (tone_phase[v]) begin
         tone_phase[v] = tone_phase[v] + PHASE_BITS'(tone_step[v]);
      end
      return SAMPLE_BITS'(mean);
   endfunction

   // wait until every outstanding sample has been returned
   task automatic drain_samples();
      req_valid <= 1'b0;
      while (sample_expect_q.size() != 0) begin
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   // register write while the block is idle, mirrored into the predictor
   task automatic program_register(input logic [CSR_INDEX_BITS-1:0] index,
                                   input logic [CSR_DATA_BITS-1:0]  data);
      drain_samples();
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (index == CSR_VOICE_COUNT) begin
         voice_setting = data[COUNT_BITS-1:0];
      end else if (index >= CSR_STEP_BASE && index < CSR_STEP_BASE + MAX_VOICES) begin
         tone_step[index - CSR_STEP_BASE] = data[STEP_BITS-1:0];
      end
   endtask

   // offer one sample request, valid stays up when no gap follows
   task automatic offer_request(input logic restart, input logic fixed,
                                input logic signed [SAMPLE_BITS-1:0] want);
      int                            gap;
      logic signed [SAMPLE_BITS-1:0] predicted;
      gap = (steady_flow || $urandom_range(0, 2) != 0) ? 0 : idle_span();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      predicted = next_chord_sample(restart);
      sample_expect_q.push_back(fixed ? want : predicted);
   endtask

   function automatic void check_sample(input logic signed [SAMPLE_BITS-1:0] got);
      logic signed [SAMPLE_BITS-1:0] want;
      if (sample_expect_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("unexpected response: sample %0d with no request pending", got);
         end
      end else begin
         want = sample_expect_q.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("sample mismatch: expected %0d, got %0d", want, got);
            end
         end
      end
   endfunction

   // response side: check each accepted sample, then pick the next ready level
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            check_sample(rsp_sample);
         end
         if (stall_left == 0) begin
            if (hold_request) begin
               // long hold-off so the block backs up into the request side
               stall_left   = LONG_HOLD;
               hold_request = 1'b0;
            end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
               stall_left = idle_span();
            end
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles where neither channel moves
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // stimulus: build the sine table, reset, directed plan, random chords, verdict
   initial begin
      longint                    ang;
      longint                    ang_sq;
      longint                    term;
      longint                    acc;
      int                        count_value;
      logic [CSR_DATA_BITS-1:0]  step_value;
      plan_row_type              row;

      // quarter-wave table from a q30 taylor series up to the x^13 term
      for (int i = 0; i <= TBL_N; i++) begin
         ang    = (QUARTER_TURN_Q30 * longint'(i)) / TBL_N;
         ang_sq = (ang * ang) >>> 30;
         term   = ang;
         acc    = ang;
         for (int k = 1; k <= 6; k++) begin
            term = ((term * ang_sq) >>> 30) / longint'((2 * k) * (2 * k + 1));
            acc  = (k % 2 == 1) ? acc - term : acc + term;
         end
         if (acc < 0) begin
            acc = 0;
         end
         quarter_wave[i] = int'((acc * longint'(AMP) + (64'sd1 <<< 29)) >>> 30);
      end

      voice_setting = COUNT_BITS'(1);
      foreach (tone_step[v]) begin
         tone_step[v]  = '0;
         tone_phase[v] = '0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_PLAN[r]) begin
         row = DIRECTED_PLAN[r];
         if (row.kind == ROW_WRITE) begin
            program_register(row.index, row.data);
         end else begin
            offer_request(row.restart, row.fixed, row.want);
         end
      end

      // random part: each phase is a new chord setup followed by a run of ticks
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         steady_flow = (phase == 1) || (phase == PRESSURE_PHASE);
         // first phases sweep every count value, including zero and seven
         count_value = (phase < 8) ? phase : $urandom_range(0, 7);
         step_value  = CSR_DATA_BITS'($urandom()) & ~CSR_DATA_BITS'((1 << COUNT_BITS) - 1);
         program_register(CSR_VOICE_COUNT, step_value | CSR_DATA_BITS'(count_value));
         for (int v = 0; v < MAX_VOICES; v++) begin
            case ($urandom_range(0, 5))
               0:       step_value = '0;
               1:       step_value = STEP_FULL;
               2:       step_value = CSR_DATA_BITS'($urandom_range(1, 4095));
               3:       step_value = CSR_DATA_BITS'($urandom_range(2000, 200000));
               default: step_value = CSR_DATA_BITS'($urandom());
            endcase
            program_register(CSR_INDEX_BITS'(CSR_STEP_BASE + v), step_value);
         end
         if ($urandom_range(0, 3) == 0) begin
            program_register(CSR_SPARE, CSR_DATA_BITS'($urandom()));
         end
         if (phase == PRESSURE_PHASE) begin
            hold_request = 1'b1;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // chords usually open with a restart, then rare restarts inside
            if (n == 0) begin
               offer_request($urandom_range(0, 7) != 0, 1'b0, '0);
            end else begin
               offer_request($urandom_range(0, 19) == 0, 1'b0, '0);
            end
         end
      end

      steady_flow = 1'b0;
      drain_samples();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/cts_pkg.sv
rtl/cts_sine_rom.sv
rtl/chord_tone_synthesizer_unit.sv
tb/tb_chord_tone_synthesizer_unit.sv
